@@ hw/rtl/dwo_pkg.sv @@
// Shared types and constants of the dual wavetable oscillator.
// Holds the operation and register index codes and the transaction structs.
// No dependencies.
`timescale 1ns / 1ps

package dwo_pkg;

    localparam int PHASE_W  = 24;
    localparam int SAMPLE_W = 16;
    localparam int MIX_W    = 20;
    localparam int GAIN_W   = 16;
    localparam int CFG_W    = 24;
    localparam int TADDR_W  = 11;

    localparam logic signed [MIX_W-1:0] MIX_MAX = 20'sh7FFFF;
    localparam logic signed [MIX_W-1:0] MIX_MIN = 20'sh80000;

    typedef enum logic [1:0] {
        OP_TABLE_WRITE = 2'd0,
        OP_SET_PHASE   = 2'd1,
        OP_SAMPLE      = 2'd2,
        OP_NONE        = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        CFG_PHASE_STEP_A = 2'd0,
        CFG_PHASE_STEP_B = 2'd1,
        CFG_DRIVE_GAIN   = 2'd2,
        CFG_VOLUME       = 2'd3
    } t_cfg_index;

    typedef struct packed {
        t_op                        operation;
        logic [TADDR_W-1:0]         table_address;
        logic signed [SAMPLE_W-1:0] table_value;
        logic [PHASE_W-1:0]         start_phase_a;
        logic [PHASE_W-1:0]         start_phase_b;
        logic signed [MIX_W-1:0]    mix_in_a;
        logic signed [MIX_W-1:0]    mix_in_b;
    } t_in_item;

    typedef struct packed {
        logic signed [MIX_W-1:0] mix_out_a;
        logic signed [MIX_W-1:0] mix_out_b;
    } t_out_item;

    typedef struct packed {
        logic adv;
    } t_stage_ctl;

endpackage

@@ hw/rtl/dwo_ram.sv @@
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module dwo_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_rd_en) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

@@ hw/rtl/dwo_voice.sv @@
// Voice datapath: drive gain and clip, volume scale, round, mix and saturate.
// Depends on dwo_pkg.
`timescale 1ns / 1ps

module dwo_voice import dwo_pkg::*; (
    input  logic                       i_clk,
    input  t_stage_ctl                 i_ctl,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic signed [MIX_W-1:0]    i_mix,
    input  logic [GAIN_W-1:0]          i_gain,
    input  logic [GAIN_W-1:0]          i_volume,
    output logic signed [MIX_W-1:0]    o_mix
);

    localparam logic signed [32:0] ClipHi = 33'sd33554432;
    localparam logic signed [32:0] ClipLo = -33'sd33554432;
    localparam logic signed [43:0] RoundBias = 44'sd16777216;

    logic signed [32:0]      prod;
    logic signed [26:0]      n_p;
    logic signed [26:0]      r_p;
    logic signed [MIX_W-1:0] r_mix2;
    logic signed [43:0]      t_full;
    logic signed [43:0]      r_t;
    logic signed [MIX_W-1:0] r_mix3;
    logic signed [43:0]      rnd;
    logic signed [18:0]      contrib;
    logic signed [MIX_W:0]   sum;

    assign prod = i_sample * $signed({1'b0, i_gain});

    always_comb begin
        priority if (prod > ClipHi) begin
            n_p = ClipHi[26:0];
        end else if (prod < ClipLo) begin
            n_p = ClipLo[26:0];
        end else begin
            n_p = prod[26:0];
        end
    end

    assign t_full = r_p * $signed({1'b0, i_volume});

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_p    <= n_p;
            r_mix2 <= i_mix;
            r_t    <= t_full;
            r_mix3 <= r_mix2;
        end
    end

    assign rnd     = r_t + RoundBias;
    assign contrib = rnd[43:25];
    assign sum     = (MIX_W+1)'(r_mix3) + (MIX_W+1)'(contrib);

    always_comb begin
        priority if (sum > (MIX_W+1)'(MIX_MAX)) begin
            o_mix = MIX_MAX;
        end else if (sum < (MIX_W+1)'(MIX_MIN)) begin
            o_mix = MIX_MIN;
        end else begin
            o_mix = sum[MIX_W-1:0];
        end
    end

endmodule

@@ hw/rtl/dual_wavetable_oscillator.sv @@
// Top level of the dual wavetable oscillator: phase registers, table, pipeline control.
// Depends on dwo_pkg, dwo_ram and dwo_voice.
`timescale 1ns / 1ps

// Two oscillators read one wave table of TABLE_SIZE/2 signed Q1.15 words held in a
// synchronous RAM with two read ports. The block takes one input transaction per
// cycle while the output register is empty or being taken; table writes and phase
// loads finish at acceptance, and a sample transaction passes four registers in
// turn: the registered table read, the drive product and the volume product of the
// two multiplies of the voice pipeline, and the output register. A result held at the
// output stalls the whole pipeline and input. Table words are undefined until
// written; no clearing pass runs after reset.
module dual_wavetable_oscillator import dwo_pkg::*; #(
    parameter int TABLE_SIZE = 4096
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  t_cfg_index i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_item   i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_item  o_out_data
);

    localparam int Depth = TABLE_SIZE / 2;
    localparam int AddrW = $clog2(Depth);

    logic [PHASE_W-1:0] r_phase_a;
    logic [PHASE_W-1:0] r_phase_b;
    logic [PHASE_W-1:0] n_phase_a;
    logic [PHASE_W-1:0] n_phase_b;
    logic [PHASE_W-1:0] r_step_a;
    logic [PHASE_W-1:0] r_step_b;
    logic [GAIN_W-1:0]  r_gain;
    logic [GAIN_W-1:0]  r_volume;
    logic               r_v1;
    logic               r_v2;
    logic               r_v3;
    logic               r_out_valid;
    t_out_item          r_out_data;
    logic signed [MIX_W-1:0] r_mix_a1;
    logic signed [MIX_W-1:0] r_mix_b1;

    logic               adv;
    logic               in_acc;
    logic               tbl_we;
    t_stage_ctl         ctl;
    logic [SAMPLE_W-1:0] rdata_a;
    logic [SAMPLE_W-1:0] rdata_b;
    logic signed [MIX_W-1:0] mix_a;
    logic signed [MIX_W-1:0] mix_b;

    assign adv        = !r_out_valid || i_out_ready;
    assign o_in_ready = adv;
    assign in_acc     = i_in_valid && adv;
    assign ctl.adv    = adv;

    assign tbl_we = in_acc && (i_in_data.operation == OP_TABLE_WRITE)
                    && (32'(i_in_data.table_address) < 32'(Depth));

    dwo_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (Depth)
    ) u_table (
        .i_clk     (i_clk),
        .i_we      (tbl_we),
        .i_waddr   (AddrW'(i_in_data.table_address)),
        .i_wdata   (i_in_data.table_value),
        .i_rd_en   (adv),
        .i_raddr_a (r_phase_a[PHASE_W-1 -: AddrW]),
        .i_raddr_b (r_phase_b[PHASE_W-1 -: AddrW]),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    dwo_voice u_voice_a (
        .i_clk    (i_clk),
        .i_ctl    (ctl),
        .i_sample ($signed(rdata_a)),
        .i_mix    (r_mix_a1),
        .i_gain   (r_gain),
        .i_volume (r_volume),
        .o_mix    (mix_a)
    );

    dwo_voice u_voice_b (
        .i_clk    (i_clk),
        .i_ctl    (ctl),
        .i_sample ($signed(rdata_b)),
        .i_mix    (r_mix_b1),
        .i_gain   (r_gain),
        .i_volume (r_volume),
        .o_mix    (mix_b)
    );

    always_comb begin
        n_phase_a = r_phase_a;
        n_phase_b = r_phase_b;
        if (in_acc) begin
            unique case (i_in_data.operation)
                OP_SET_PHASE: begin
                    n_phase_a = i_in_data.start_phase_a;
                    n_phase_b = i_in_data.start_phase_b;
                end
                OP_SAMPLE: begin
                    n_phase_a = r_phase_a + r_step_a;
                    n_phase_b = r_phase_b + r_step_b;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_a   <= '0;
            r_phase_b   <= '0;
            r_step_a    <= '0;
            r_step_b    <= '0;
            r_gain      <= 16'd1024;
            r_volume    <= 16'd32768;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase_a <= n_phase_a;
            r_phase_b <= n_phase_b;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_PHASE_STEP_A: r_step_a <= i_cfg_wdata;
                    CFG_PHASE_STEP_B: r_step_b <= i_cfg_wdata;
                    CFG_DRIVE_GAIN:   r_gain   <= i_cfg_wdata[GAIN_W-1:0];
                    CFG_VOLUME:       r_volume <= i_cfg_wdata[GAIN_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (adv) begin
                r_v1        <= in_acc && (i_in_data.operation == OP_SAMPLE);
                r_v2        <= r_v1;
                r_v3        <= r_v2;
                r_out_valid <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_mix_a1             <= i_in_data.mix_in_a;
            r_mix_b1             <= i_in_data.mix_in_b;
            r_out_data.mix_out_a <= mix_a;
            r_out_data.mix_out_b <= mix_b;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_sample_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_in_data.operation == OP_SAMPLE) |=> r_v1)
        else $error("accepted sample did not enter the pipeline");

    a_phase_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && in_acc && (i_in_data.operation == OP_SAMPLE)
        |=> r_phase_a == $past(r_phase_a + r_step_a))
        else $error("phase A did not advance by its step");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && r_out_valid && !i_out_ready |=> r_v3)
        else $error("stalled pipeline dropped a sample");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_v3))
        else $error("result appeared without a sample in the last stage");

endmodule

@@ verif/dual_wavetable_oscillator_test.sv @@
// Self-checking testbench for dual_wavetable_oscillator: random and directed table writes,
// phase loads and sample transactions, checked against an in-bench prediction of the mix.
// Depends on dwo_pkg and the dual_wavetable_oscillator RTL.
`timescale 1ns / 1ps

module dual_wavetable_oscillator_test;
    import dwo_pkg::*;

    localparam int TABLE_SIZE   = 4096;
    localparam int HALF_TABLE   = TABLE_SIZE / 2;
    localparam int DRAIN_CYCLES = 8;
    localparam longint CLIP_ONE   = 64'sd1 <<< 25;
    localparam longint ROUND_HALF = 64'sd1 <<< 24;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_we = 1'b0;
    t_cfg_index       i_cfg_index = CFG_PHASE_STEP_A;
    logic [CFG_W-1:0] i_cfg_wdata = '0;
    logic             i_in_valid = 1'b0;
    logic             o_in_ready;
    t_in_item         i_in_data = '0;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    t_out_item        o_out_data;

    dual_wavetable_oscillator #(.TABLE_SIZE(TABLE_SIZE)) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    always #4 i_clk = ~i_clk;

    // stimulus side
    t_in_item          pending_items[$];
    int unsigned       send_idle_pct = 38;
    int unsigned       recv_idle_pct = 38;
    int unsigned       n_sent = 0;
    logic [PHASE_W-1:0] gen_phase_a = '0, gen_phase_b = '0;
    logic [PHASE_W-1:0] gen_step_a = '0, gen_step_b = '0;
    bit                gen_written[HALF_TABLE];
    int unsigned       n_settings = 1;

    // prediction side
    logic signed [SAMPLE_W-1:0] tone_table[HALF_TABLE];
    logic [PHASE_W-1:0] osc_phase_a, osc_phase_b;
    logic [PHASE_W-1:0] osc_step_a, osc_step_b;
    logic [GAIN_W-1:0]  osc_drive, osc_volume;
    t_out_item          expected_mix[$];
    int unsigned        n_accepted = 0;
    int unsigned        n_writes = 0, n_loads = 0, n_samples = 0, n_ignored = 0;
    int unsigned        n_checked = 0, mismatches = 0;

    function automatic logic signed [MIX_W-1:0] mix_voice(logic [PHASE_W-1:0] phase,
                                                          logic signed [MIX_W-1:0] mix_in);
        longint idx, smp, prod, scaled, sum;
        idx = (longint'(phase) * HALF_TABLE) >>> PHASE_W;
        if (idx >= HALF_TABLE) begin
            idx = HALF_TABLE - 1;
        end
        smp  = tone_table[idx];
        prod = smp * longint'(osc_drive);
        if (prod > CLIP_ONE) begin
            prod = CLIP_ONE;
        end
        if (prod < -CLIP_ONE) begin
            prod = -CLIP_ONE;
        end
        scaled = prod * longint'(osc_volume);
        sum = longint'(mix_in) + ((scaled + ROUND_HALF) >>> 25);
        if (sum > longint'(MIX_MAX)) begin
            sum = longint'(MIX_MAX);
        end
        if (sum < longint'(MIX_MIN)) begin
            sum = longint'(MIX_MIN);
        end
        return sum[MIX_W-1:0];
    endfunction

    function automatic void predict_transaction(t_in_item item);
        t_out_item res;
        case (item.operation)
            OP_TABLE_WRITE: begin
                if (int'(item.table_address) < HALF_TABLE) begin
                    tone_table[item.table_address] = item.table_value;
                end
                n_writes++;
            end
            OP_SET_PHASE: begin
                osc_phase_a = item.start_phase_a;
                osc_phase_b = item.start_phase_b;
                n_loads++;
            end
            OP_SAMPLE: begin
                res.mix_out_a = mix_voice(osc_phase_a, item.mix_in_a);
                res.mix_out_b = mix_voice(osc_phase_b, item.mix_in_b);
                expected_mix.push_back(res);
                osc_phase_a = osc_phase_a + osc_step_a;
                osc_phase_b = osc_phase_b + osc_step_b;
                n_samples++;
            end
            default: n_ignored++;
        endcase
    endfunction

    function automatic void note_mismatch(string field, logic signed [MIX_W-1:0] exp_val,
                                          logic signed [MIX_W-1:0] act_val);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch on %s at %0t: expected %0d, got %0d",
                     field, $realtime, exp_val, act_val);
        end
    endfunction

    function automatic void check_result(t_out_item got);
        t_out_item want;
        if (expected_mix.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("unexpected result at %0t: a=%0d b=%0d",
                         $realtime, got.mix_out_a, got.mix_out_b);
            end
            return;
        end
        want = expected_mix.pop_front();
        n_checked++;
        if (got.mix_out_a !== want.mix_out_a) begin
            note_mismatch("mix_out_a", want.mix_out_a, got.mix_out_a);
        end
        if (got.mix_out_b !== want.mix_out_b) begin
            note_mismatch("mix_out_b", want.mix_out_b, got.mix_out_b);
        end
    endfunction

    // driver: hold valid and payload until the transaction is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_in_valid <= 1'b1;
                i_in_data  <= pending_items.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // monitor: track configuration, check results, predict accepted transactions
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            osc_phase_a = '0;
            osc_phase_b = '0;
            osc_step_a  = '0;
            osc_step_b  = '0;
            osc_drive   = 16'd1024;
            osc_volume  = 16'd32768;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_PHASE_STEP_A: osc_step_a = i_cfg_wdata[PHASE_W-1:0];
                    CFG_PHASE_STEP_B: osc_step_b = i_cfg_wdata[PHASE_W-1:0];
                    CFG_DRIVE_GAIN:   osc_drive  = i_cfg_wdata[GAIN_W-1:0];
                    CFG_VOLUME:       osc_volume = i_cfg_wdata[GAIN_W-1:0];
                    default: ;
                endcase
            end
            if (o_out_valid && i_out_ready) begin
                check_result(o_out_data);
            end
            if (i_in_valid && o_in_ready) begin
                predict_transaction(i_in_data);
                n_accepted++;
            end
        end
    end

    function automatic int unsigned table_index(logic [PHASE_W-1:0] phase);
        return int'((longint'(phase) * HALF_TABLE) >>> PHASE_W);
    endfunction

    function automatic t_in_item random_item();
        t_in_item it;
        it.operation     = t_op'($urandom_range(3));
        it.table_address = TADDR_W'($urandom);
        it.table_value   = SAMPLE_W'($urandom);
        it.start_phase_a = PHASE_W'($urandom);
        it.start_phase_b = PHASE_W'($urandom);
        it.mix_in_a      = MIX_W'($urandom);
        it.mix_in_b      = MIX_W'($urandom);
        return it;
    endfunction

    function automatic logic signed [MIX_W-1:0] pick_mix();
        case ($urandom_range(7))
            0: return MIX_MAX;
            1: return MIX_MIN;
            default: return MIX_W'($urandom);
        endcase
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(7))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic send(t_in_item it);
        pending_items.push_back(it);
        n_sent++;
    endtask

    task automatic gen_write(logic [TADDR_W-1:0] addr, logic signed [SAMPLE_W-1:0] value);
        t_in_item it;
        it = random_item();
        it.operation     = OP_TABLE_WRITE;
        it.table_address = addr;
        it.table_value   = value;
        if (int'(addr) < HALF_TABLE) begin
            gen_written[addr] = 1'b1;
        end
        send(it);
    endtask

    task automatic gen_set_phase(logic [PHASE_W-1:0] pa, logic [PHASE_W-1:0] pb);
        t_in_item it;
        it = random_item();
        it.operation     = OP_SET_PHASE;
        it.start_phase_a = pa;
        it.start_phase_b = pb;
        gen_phase_a = pa;
        gen_phase_b = pb;
        send(it);
    endtask

    // queue a sample, first filling any entry it reads that was never written
    task automatic gen_sample(logic signed [MIX_W-1:0] ma, logic signed [MIX_W-1:0] mb);
        t_in_item    it;
        int unsigned ia, ib;
        ia = table_index(gen_phase_a);
        ib = table_index(gen_phase_b);
        if (!gen_written[ia]) begin
            gen_write(TADDR_W'(ia), pick_sample());
        end
        if (!gen_written[ib]) begin
            gen_write(TADDR_W'(ib), pick_sample());
        end
        it = random_item();
        it.operation = OP_SAMPLE;
        it.mix_in_a  = ma;
        it.mix_in_b  = mb;
        gen_phase_a  = gen_phase_a + gen_step_a;
        gen_phase_b  = gen_phase_b + gen_step_b;
        send(it);
    endtask

    task automatic gen_ignored(t_in_item it);
        it.operation = OP_NONE;
        send(it);
    endtask

    task automatic gen_random(int unsigned count);
        int unsigned base;
        int unsigned pick;
        base = n_sent;
        while (n_sent - base < count) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                gen_sample(pick_mix(), pick_mix());
            end else if (pick < 85) begin
                gen_write(TADDR_W'($urandom), pick_sample());
            end else if (pick < 95) begin
                gen_set_phase(PHASE_W'($urandom), PHASE_W'($urandom));
            end else begin
                gen_ignored(random_item());
            end
        end
    endtask

    task automatic wait_idle();
        while (n_accepted != n_sent || expected_mix.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_index idx, logic [CFG_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        if (idx == CFG_PHASE_STEP_A) begin
            gen_step_a = value[PHASE_W-1:0];
        end
        if (idx == CFG_PHASE_STEP_B) begin
            gen_step_b = value[PHASE_W-1:0];
        end
    endtask

    task automatic program_regs(logic [PHASE_W-1:0] step_a, logic [PHASE_W-1:0] step_b,
                                logic [GAIN_W-1:0] drive, logic [GAIN_W-1:0] vol);
        wait_idle();
        write_reg(CFG_PHASE_STEP_A, CFG_W'(step_a));
        write_reg(CFG_PHASE_STEP_B, CFG_W'(step_b));
        write_reg(CFG_DRIVE_GAIN, CFG_W'(drive));
        write_reg(CFG_VOLUME, CFG_W'(vol));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    initial begin
        t_in_item ones;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, reset configuration: steps zero, unity drive and volume
        gen_write(11'd0, 16'sh7FFF);
        gen_write(11'd2047, 16'sh8000);
        gen_write(11'd1024, 16'sh0000);
        gen_write(11'd1, -16'sd1);
        gen_sample(20'sd0, 20'sd0);
        gen_sample(MIX_MAX, MIX_MAX);
        gen_set_phase(24'hFFFFFF, 24'h800000);
        gen_sample(MIX_MIN, 20'sd0);
        gen_sample(MIX_MAX, MIX_MIN);
        gen_ignored(random_item());
        gen_set_phase(24'h001FFF, 24'h002000);
        gen_sample(20'sd0, MIX_MIN);
        ones = '1;
        gen_ignored(ones);
        gen_write(11'd0, 16'sh4000);
        gen_set_phase(24'h000000, 24'h000000);
        gen_sample(20'sd5, -20'sd5);

        program_regs(24'h000400, 24'h000401, 16'd1024, 16'd32768);
        gen_random(215);

        // phase wrap both ways, full drive
        program_regs(24'hFFFFFF, 24'h000001, 16'd33792, 16'd32768);
        gen_set_phase(24'h000000, 24'hFFFFFF);
        repeat (4) gen_sample(pick_mix(), pick_mix());
        gen_random(215);

        program_regs(PHASE_W'($urandom), PHASE_W'($urandom), 16'hFFFF, 16'hFFFF);
        gen_random(110);
        wait_idle();
        gen_random(105);

        program_regs(PHASE_W'($urandom), PHASE_W'($urandom), 16'd0, 16'd0);
        gen_random(215);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        program_regs(PHASE_W'($urandom), PHASE_W'($urandom),
                     GAIN_W'($urandom_range(33792, 1024)), GAIN_W'($urandom_range(32768)));
        gen_random(215);
        wait_idle();
        send_idle_pct = 38;
        recv_idle_pct = 38;

        program_regs(24'h800000, 24'h7FFFFF, 16'd2048, 16'd16384);
        gen_random(215);
        wait_idle();

        $display("Covered %0d table writes, %0d phase loads, %0d samples (%0d checked)",
                 n_writes, n_loads, n_samples, n_checked);
        $display("and %0d ignored transactions over %0d register settings, %0d mismatches.",
                 n_ignored, n_settings, mismatches);
        if (mismatches == 0 && expected_mix.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("timeout at %0t with %0d results outstanding", $realtime, expected_mix.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
